>>> sv/assert_macros.svh
// Assertion macros shared by the downsampler RTL.
// Needs a signal named clk and a signal named rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CHECK_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> sv/bd_pkg.sv
// Package for the 2x2 box downsampler: sizes, register codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bd_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int IDX_W        = $clog2(LINE_DEPTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  // Width comparisons need room for both the register and the largest width.
  localparam int WCMP_W = (WIDTH_REG_W > COL_W + 1) ? WIDTH_REG_W : COL_W + 1;

  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HEIGHT_REG_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int CHAN_W = 8;
  localparam int PAIR_W = CHAN_W + 1;
  localparam int QUAD_W = CHAN_W + 2;

  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pixel_t;

  // Hand-off from the front end to the merge stage.
  typedef struct packed {
    logic issue;
    logic last;
  } front_ctl_t;

endpackage

>>> sv/bd_if.sv
// Stream interfaces for the downsampler: input pixels and output block averages.
// Depends on bd_pkg.
`timescale 1ns / 1ps

interface bd_in_if;
  import bd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bd_out_if;
  import bd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

>>> sv/bd_line_ram.sv
// Simple dual-port line store with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bd_line_ram #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 27,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/bd_front.sv
// Front end: size registers, raster counters, held pixel and horizontal pair sums.
// Drives the line store ports. Depends on bd_pkg.
`timescale 1ns / 1ps

module bd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          accept,
  input  bd_pkg::pixel_t                pixel,
  output logic                          ram_we,
  output logic [bd_pkg::IDX_W-1:0]      ram_waddr,
  output bd_pkg::pair_sum_t             ram_wdata,
  output logic                          ram_re,
  output logic [bd_pkg::IDX_W-1:0]      ram_raddr,
  output bd_pkg::front_ctl_t            ctl,
  output bd_pkg::pair_sum_t             pair_sum
);
  import bd_pkg::*;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_count;
  pixel_t                  held_pixel;

  logic [WCMP_W-1:0]       eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [WCMP_W-1:0]       col_inc;
  logic [HEIGHT_REG_W-1:0] row_inc;
  logic [WCMP_W-1:0]       last_col;
  logic [HEIGHT_REG_W-1:0] last_row;
  logic                    odd_col;
  logic                    odd_row;
  logic [IDX_W-1:0]        idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(WIDTH_RESET);
      image_height <= HEIGHT_REG_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes outside the supported range are saturated.
  always_comb begin
    eff_w = WCMP_W'(image_width);
    if (eff_w < WCMP_W'(2)) begin
      eff_w = WCMP_W'(2);
    end else if (eff_w > WCMP_W'(MAX_WIDTH)) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end
    eff_h = image_height;
    if (eff_h < HEIGHT_REG_W'(2)) begin
      eff_h = HEIGHT_REG_W'(2);
    end else if (eff_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  assign col_inc  = WCMP_W'(column_count) + WCMP_W'(1);
  assign row_inc  = HEIGHT_REG_W'(row_count) + HEIGHT_REG_W'(1);
  assign last_col = {eff_w[WCMP_W-1:1], 1'b0} - WCMP_W'(1);
  assign last_row = {eff_h[HEIGHT_REG_W-1:1], 1'b0} - HEIGHT_REG_W'(1);
  assign odd_col  = column_count[0];
  assign odd_row  = row_count[0];
  assign idx      = column_count[COL_W-1:1];

  assign pair_sum.r = {1'b0, held_pixel.r} + {1'b0, pixel.r};
  assign pair_sum.g = {1'b0, held_pixel.g} + {1'b0, pixel.g};
  assign pair_sum.b = {1'b0, held_pixel.b} + {1'b0, pixel.b};

  // Even rows store the pair sums; odd rows fetch them for the merge stage.
  // A write and the read of the same entry are at least one item apart, and
  // the write lands at the edge that accepts it, so no forwarding is needed.
  assign ram_we    = accept && odd_col && !odd_row;
  assign ram_waddr = idx;
  assign ram_wdata = pair_sum;
  assign ram_re    = accept && odd_col && odd_row;
  assign ram_raddr = idx;

  assign ctl.issue = ram_re;
  assign ctl.last  = (WCMP_W'(column_count) == last_col) &&
                     (HEIGHT_REG_W'(row_count) == last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (accept) begin
      if (!odd_col) begin
        held_pixel <= pixel;
      end
      if (col_inc >= eff_w) begin
        column_count <= '0;
        row_count    <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

>>> sv/bd_merge.sv
// Merge stage: adds the fetched line sums to the current pair sums and holds
// the result in an output register. Depends on bd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bd_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  bd_pkg::front_ctl_t        ctl,
  input  bd_pkg::pair_sum_t         pair_sum,
  input  bd_pkg::pair_sum_t         line_sum,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bd_pkg::pixel_t            out_pixel,
  output logic                      out_last
);
  import bd_pkg::*;

  logic              s1_valid;
  pair_sum_t         s1_sum;
  logic              s1_last;
  logic              move;
  logic [QUAD_W-1:0] tot_r;
  logic [QUAD_W-1:0] tot_g;
  logic [QUAD_W-1:0] tot_b;

  // The stage moves on whenever the output register is empty or being emptied.
  assign move     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || move;

  assign tot_r = {1'b0, s1_sum.r} + {1'b0, line_sum.r};
  assign tot_g = {1'b0, s1_sum.g} + {1'b0, line_sum.g};
  assign tot_b = {1'b0, s1_sum.b} + {1'b0, line_sum.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.issue) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      s1_sum  <= pair_sum;
      s1_last <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Dividing the four-value sum by four keeps its top eight bits.
  always_ff @(posedge clk) begin
    if (move) begin
      out_pixel.r <= tot_r[QUAD_W-1:2];
      out_pixel.g <= tot_g[QUAD_W-1:2];
      out_pixel.b <= tot_b[QUAD_W-1:2];
      out_last    <= s1_last;
    end
  end

  `CHECK_SAME(a_issue_has_slot, ctl.issue, !s1_valid || move, "item issued into a busy stage")
  `CHECK_NEXT(a_move_fills_out, move, out_valid, "moved item did not reach the output")
  `CHECK_NEXT(a_stall_holds, s1_valid && !move, s1_valid && $stable(s1_sum), "stalled stage lost its item")

endmodule

>>> sv/box_downsample_2x2.sv
// Top level of the 2x2 box downsampler for RGB888 raster streams.
// Depends on bd_pkg, bd_if, bd_line_ram, bd_front and bd_merge.
//
//   port    | direction | carries
//   --------+-----------+------------------------------------------------
//   pixel   | sink      | red_in, green_in, blue_in, one item per pixel
//   result  | source    | red_out, green_out, blue_out, frame_last
//   cfg     | write     | image_width (index 0), image_height (index 1)
//
// One input item per clock when the output is taken. After its last pixel is
// accepted, a block average passes the line store read and merge stage register,
// then the final add into the output register. Reset clears counters, the held
// pixel and the pipeline valids; the line store is not cleared, as every entry is
// written on an even row before it is read. A stalled output holds one item in the
// output register and one in the merge stage before input stops.
`timescale 1ns / 1ps

module box_downsample_2x2 (
  input  logic                          clk,
  input  logic                          rst,
  bd_in_if.sink                         pixel,
  bd_out_if.source                      result,
  input  logic                          cfg_write,
  input  logic [bd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bd_pkg::*;

  logic             in_ready;
  logic             accept;
  pixel_t           in_pixel;
  pixel_t           out_pixel;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  pair_sum_t        ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  pair_sum_t        line_sum;
  front_ctl_t       ctl;
  pair_sum_t        pair_sum;

  assign pixel.ready = in_ready;
  assign accept      = pixel.valid && in_ready;
  assign in_pixel.r  = pixel.red_in;
  assign in_pixel.g  = pixel.green_in;
  assign in_pixel.b  = pixel.blue_in;

  bd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (in_pixel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ctl       (ctl),
    .pair_sum  (pair_sum)
  );

  bd_line_ram #(
    .DEPTH  (LINE_DEPTH),
    .DATA_W ($bits(pair_sum_t))
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (line_sum)
  );

  bd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .pair_sum  (pair_sum),
    .line_sum  (line_sum),
    .in_ready  (in_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_pixel (out_pixel),
    .out_last  (result.frame_last)
  );

  assign result.red_out   = out_pixel.r;
  assign result.green_out = out_pixel.g;
  assign result.blue_out  = out_pixel.b;

endmodule

>>> verif/box_downsample_2x2_tb.sv
// Self-checking testbench for box_downsample_2x2: directed runs, a table, random frames;
// all checked against a 2x2 average predictor. Needs bd_pkg, bd_if, box_downsample_2x2.
`timescale 1ns / 1ps

module box_downsample_2x2_tb;
  import bd_pkg::*;

  // Cycles allowed after the last expected average for pixels that give no result.
  localparam int PIPE_SLACK   = 6;
  localparam int RANDOM_ITEMS = 200;
  localparam int LONG_HOLD    = 80;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } block_avg_t;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    pixel_t                 px;
    bit                     typed;
    block_avg_t             avg;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bd_in_if  in_ch ();
  bd_out_if out_ch ();

  box_downsample_2x2 dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (in_ch),
    .result    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [COL_W-1:0]        col_pos;
  logic [ROW_W-1:0]        row_pos;
  pixel_t                  held_px;
  pair_sum_t               pair_line [LINE_DEPTH];

  block_avg_t pending_avgs [$];
  step_t      dir_steps [$];
  int         errors;
  int         items_sent;
  int         send_gap_pct;
  int         take_stall_pct;
  bit         long_hold_req;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Advances the predictor by one pixel; returns 1 when the pixel closes a 2x2 block.
  function automatic bit predict_pixel(input pixel_t p, output block_avg_t avg);
    int unsigned       w;
    int unsigned       h;
    int unsigned       last_col;
    int unsigned       last_row;
    pair_sum_t         s;
    pair_sum_t         e;
    logic [QUAD_W-1:0] tr;
    logic [QUAD_W-1:0] tg;
    logic [QUAD_W-1:0] tb;
    w = clamp_size(width_reg, 2, MAX_WIDTH);
    h = clamp_size(height_reg, 2, MAX_HEIGHT);
    predict_pixel = 1'b0;
    avg = '0;
    if (!col_pos[0]) begin
      held_px = p;
    end else begin
      s.r = held_px.r + p.r;
      s.g = held_px.g + p.g;
      s.b = held_px.b + p.b;
      if (!row_pos[0]) begin
        pair_line[col_pos[COL_W-1:1]] = s;
      end else begin
        e = pair_line[col_pos[COL_W-1:1]];
        tr = s.r + e.r;
        tg = s.g + e.g;
        tb = s.b + e.b;
        last_col = (w / 2) * 2 - 1;
        last_row = (h / 2) * 2 - 1;
        avg.px.r = tr[QUAD_W-1:2];
        avg.px.g = tg[QUAD_W-1:2];
        avg.px.b = tb[QUAD_W-1:2];
        avg.last = (32'(col_pos) == last_col) && (32'(row_pos) == last_row);
        predict_pixel = 1'b1;
      end
    end
    // A count left past the size by a smaller setting wraps on this pixel.
    if (32'(col_pos) + 1 >= w) begin
      col_pos = '0;
      row_pos = (32'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic int idle_burst(int pct);
    return (pct > 0 && $urandom_range(99) < pct) ? $urandom_range(1, 5) : 0;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.r = rand_channel();
    p.g = rand_channel();
    p.b = rand_channel();
    return p;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{kind: STEP_CFG, idx: idx, data: data, px: '0, typed: 1'b0, avg: '0};
    dir_steps.push_back(s);
  endfunction

  function automatic void add_pix(pixel_t p, bit typed = 1'b0, pixel_t avg = '0,
                                  logic last = 1'b0);
    step_t s;
    s = '{kind: STEP_PIXEL, idx: '0, data: '0, px: p, typed: typed, avg: '0};
    s.avg.px = avg;
    s.avg.last = last;
    dir_steps.push_back(s);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data[WIDTH_REG_W-1:0];
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data;
    end
  endtask

  // Offers one pixel and returns once it has been taken; a typed average replaces the
  // predicted one as the expectation for that pixel.
  task automatic push_pixel(input pixel_t p, input bit typed = 1'b0,
                            input block_avg_t typed_avg = '0);
    int         gap;
    block_avg_t avg;
    gap = idle_burst(send_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= p.r;
    in_ch.green_in <= p.g;
    in_ch.blue_in  <= p.b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (predict_pixel(p, avg)) begin
      pending_avgs.push_back(typed ? typed_avg : avg);
    end
  endtask

  task automatic drain(input int limit);
    int n;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    n = 0;
    while (pending_avgs.size() != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // Output side: random stalls, and one long hold-off when asked for.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        stall = idle_burst(take_stall_pct);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end else begin
          out_ch.ready <= 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    block_avg_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_avgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected block average, expected none, actual r=%0d g=%0d b=%0d last=%0d",
                 $time, out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.frame_last);
      end else begin
        want = pending_avgs.pop_front();
        check_field("red_out", want.px.r, out_ch.red_out);
        check_field("green_out", want.px.g, out_ch.green_out);
        check_field("blue_out", want.px.b, out_ch.blue_out);
        check_field("frame_last", {7'b0, want.last}, {7'b0, out_ch.frame_last});
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    pixel_t      white;
    pixel_t      teal;
    pixel_t      blk;
    pixel_t      drop;
    int          w_data;
    int          h_data;
    int          frame;
    int          count;
    int          random_items;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    errors         = 0;
    items_sent     = 0;
    send_gap_pct   = 30;
    take_stall_pct = 30;
    long_hold_req  = 1'b0;
    width_reg      = WIDTH_RESET;
    height_reg     = HEIGHT_RESET;
    col_pos        = '0;
    row_pos        = '0;
    held_px        = '0;
    foreach (pair_line[i]) pair_line[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes: one full row at the reset width fills the first half of the line
    // store, and the first pair of the next row gives an average only if that width holds.
    repeat (WIDTH_RESET + 2) push_pixel(random_pixel());

    white = '{8'd255, 8'd255, 8'd255};
    teal  = '{8'd10, 8'd20, 8'd30};
    blk   = '{8'd100, 8'd150, 8'd200};
    drop  = '{8'd255, 8'd0, 8'd255};

    add_cfg(REG_IMAGE_WIDTH, 13'd2);
    add_cfg(REG_IMAGE_HEIGHT, 13'd2);
    // The column count now lies past the new width, so this pixel wraps to the frame start.
    add_pix('{8'd1, 8'd2, 8'd3});
    repeat (3) add_pix(white);
    add_pix(white, 1'b1, white, 1'b1);
    // Truncation: red sums to 11, green to 1019, blue to 3.
    add_pix('{8'd3, 8'd255, 8'd0});
    add_pix('{8'd3, 8'd254, 8'd1});
    add_pix('{8'd2, 8'd255, 8'd1});
    add_pix('{8'd3, 8'd255, 8'd1}, 1'b1, '{8'd2, 8'd254, 8'd0}, 1'b1);
    // Sizes below the minimum are taken as 2.
    add_cfg(REG_IMAGE_WIDTH, 13'd0);
    add_cfg(REG_IMAGE_HEIGHT, 13'd1);
    repeat (3) add_pix(teal);
    add_pix(teal, 1'b1, teal, 1'b1);
    // Upper data bits are dropped from the width, leaving 3; the odd last column and
    // row must not reach the average. A write to an unused index changes nothing.
    add_cfg(REG_IMAGE_WIDTH, 13'h1803);
    add_cfg(REG_IMAGE_HEIGHT, 13'd3);
    add_cfg(REG_SPARE, 13'h1FFF);
    add_pix(blk);
    add_pix(blk);
    add_pix(drop);
    add_pix(blk);
    add_pix(blk, 1'b1, blk, 1'b1);
    add_pix(drop);
    repeat (3) add_pix(drop);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) begin
        drain(2000);
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      end else begin
        push_pixel(dir_steps[i].px, dir_steps[i].typed, dir_steps[i].avg);
      end
    end

    // Widest frame: the first row writes every line store entry, and the first pairs
    // of the next row read back only if the width is clamped.
    drain(2000);
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    repeat (MAX_WIDTH + 4) push_pixel(random_pixel());

    // The output holds off for a long stretch while pixels keep coming.
    drain(2000);
    write_reg(REG_IMAGE_WIDTH, 13'd16);
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    send_gap_pct  = 0;
    long_hold_req = 1'b1;
    repeat (64) push_pixel(random_pixel());

    // Height taken from the largest register value; a few rows are run.
    drain(2000);
    send_gap_pct   = 10;
    take_stall_pct = 10;
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (32) push_pixel(random_pixel());

    // Small random frames; now and then a frame is cut short and the sizes change mid-frame.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items > RANDOM_ITEMS - 100) begin
        send_gap_pct   = 0;
        take_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: send_gap_pct = 0;
          1: send_gap_pct = 10;
          default: send_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: take_stall_pct = 0;
          1: take_stall_pct = 10;
          default: take_stall_pct = 40;
        endcase
      end
      w_data = $urandom_range(2, 24);
      if ($urandom_range(0, 7) == 0) w_data += $urandom_range(1, 3) << WIDTH_REG_W;
      if ($urandom_range(0, 9) == 0) w_data = $urandom_range(0, 1);
      h_data = $urandom_range(2, 8);
      if ($urandom_range(0, 9) == 0) h_data = $urandom_range(0, 1);
      drain(2000);
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_data));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_data));
      frame = clamp_size(width_reg, 2, MAX_WIDTH) * clamp_size(height_reg, 2, MAX_HEIGHT);
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, frame) : frame;
      repeat (count) push_pixel(random_pixel());
      random_items += count;
    end

    drain(5000);
    if (pending_avgs.size() != 0) begin
      errors += pending_avgs.size();
      $display("%0t: %0d expected block averages never arrived", $time, pending_avgs.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
